>>> hw/rtl/cps_pkg.sv
// Shared types, constants and helpers of the chord progression sequencer.
package cps_pkg;

    // Number of chord slots the sequencer can step through
    localparam int unsigned SLOTS = 8;

    // Register field widths
    localparam int unsigned PERIOD_W = 22;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned ROOTS_W  = 32;
    localparam int unsigned MINOR_W  = 8;
    localparam int unsigned BEATS_W  = 48;
    localparam int unsigned CFG_W    = 48;
    localparam int unsigned IDX_W    = 3;

    // State widths
    localparam int unsigned BEAT_W = 6;
    localparam int unsigned SLOT_W = 3;
    localparam int unsigned STEPS_W = 28;

    localparam logic [PERIOD_W-1:0] TICK_MAX = '1;
    localparam logic [BEAT_W-1:0]   BEAT_MAX = 6'd32;

    // Packed scale intervals, interval k at bits 4k+3..4k
    localparam logic [STEPS_W-1:0] MAJOR_STEPS = 28'hB975420;
    localparam logic [STEPS_W-1:0] MINOR_STEPS = 28'hA875320;

    // Register reset values
    localparam logic [PERIOD_W-1:0] RST_BEAT_PERIOD = 22'd500000;
    localparam logic [COUNT_W-1:0]  RST_SLOT_COUNT  = 4'd0;
    localparam logic [ROOTS_W-1:0]  RST_SLOT_ROOTS  = 32'd29993;
    localparam logic [MINOR_W-1:0]  RST_SLOT_MINOR  = 8'd11;
    localparam logic [BEATS_W-1:0]  RST_SLOT_BEATS  = 48'd35742854185488;

    // Register indexes on the write port
    typedef enum logic [IDX_W-1:0] {
        REG_BEAT_PERIOD = 3'd0,
        REG_SLOT_COUNT  = 3'd1,
        REG_SLOT_ROOTS  = 3'd2,
        REG_SLOT_MINOR  = 3'd3,
        REG_SLOT_BEATS  = 3'd4
    } t_reg_idx;

    // Configuration as seen by the sequencer datapath
    typedef struct packed {
        logic [PERIOD_W-1:0] beat_period;
        logic [COUNT_W-1:0]  slot_count;
        logic [ROOTS_W-1:0]  slot_roots;
        logic [MINOR_W-1:0]  slot_minor;
        logic [BEATS_W-1:0]  slot_beats;
    } t_cfg;

    // Beat length of a slot: zero means one, above 32 saturates
    function automatic logic [BEAT_W-1:0] beat_len(input logic [BEAT_W-1:0] raw);
        logic [BEAT_W-1:0] len;
        len = raw;
        if (len == '0) begin
            len = 6'd1;
        end else if (len > BEAT_MAX) begin
            len = BEAT_MAX;
        end
        return len;
    endfunction

endpackage

>>> hw/rtl/cps_cfg.sv
// Configuration register file of the chord progression sequencer.
module cps_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cps_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]   i_cfg_data,
    output cps_pkg::t_cfg               o_cfg
);

    cps_pkg::t_cfg r_cfg;
    cps_pkg::t_cfg n_cfg;

    // Decode the write index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (cps_pkg::t_reg_idx'(i_cfg_index))
                cps_pkg::REG_BEAT_PERIOD: begin
                    n_cfg.beat_period = i_cfg_data[cps_pkg::PERIOD_W-1:0];
                end
                cps_pkg::REG_SLOT_COUNT: begin
                    n_cfg.slot_count = i_cfg_data[cps_pkg::COUNT_W-1:0];
                end
                cps_pkg::REG_SLOT_ROOTS: begin
                    n_cfg.slot_roots = i_cfg_data[cps_pkg::ROOTS_W-1:0];
                end
                cps_pkg::REG_SLOT_MINOR: begin
                    n_cfg.slot_minor = i_cfg_data[cps_pkg::MINOR_W-1:0];
                end
                cps_pkg::REG_SLOT_BEATS: begin
                    n_cfg.slot_beats = i_cfg_data[cps_pkg::BEATS_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beat_period <= cps_pkg::RST_BEAT_PERIOD;
            r_cfg.slot_count  <= cps_pkg::RST_SLOT_COUNT;
            r_cfg.slot_roots  <= cps_pkg::RST_SLOT_ROOTS;
            r_cfg.slot_minor  <= cps_pkg::RST_SLOT_MINOR;
            r_cfg.slot_beats  <= cps_pkg::RST_SLOT_BEATS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/chord_progression_sequencer_core.sv
// Top level of the chord progression sequencer: counters, slot stepping, result register.
// The result of an accepted item is written into the output register at the accepting clock edge.
// Throughput: one item per cycle; the counter update and chord lookup sit in one stage.
// The input is stalled only while a result is held and the output side stalls.
// Synchronous active-low reset clears the counters to slot 0, beat 0, tick 0, empties
// the output register and loads the register defaults (no slots active).
module chord_progression_sequencer_core #(
    parameter int unsigned SLOTS = cps_pkg::SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_restart,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [3:0]                  o_root_note,
    output logic                        o_is_minor,
    output logic [2:0]                  o_slot_index,
    output logic [4:0]                  o_beat_index,
    output logic                        o_beat_pulse,
    output logic                        o_chord_change,
    output logic                        o_active,
    output logic [27:0]                 o_scale_steps,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [cps_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]   i_cfg_data
);

    cps_pkg::t_cfg w_cfg;

    cps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer state
    logic [cps_pkg::PERIOD_W-1:0] r_tick, n_tick;
    logic [cps_pkg::BEAT_W-1:0]   r_beat, n_beat;
    logic [cps_pkg::SLOT_W-1:0]   r_slot, n_slot;

    // Result register
    logic                         r_out_valid;
    logic [3:0]                   r_root, n_root;
    logic                         r_minor, n_minor;
    logic [2:0]                   r_slot_idx, n_slot_idx;
    logic [4:0]                   r_beat_idx, n_beat_idx;
    logic                         r_pulse, n_pulse;
    logic                         r_change, n_change;
    logic                         r_active, n_active;
    logic [27:0]                  r_steps, n_steps;

    logic                         w_accept;
    logic [cps_pkg::COUNT_W-1:0]  w_nslots;
    logic [cps_pkg::PERIOD_W-1:0] w_period;
    logic [cps_pkg::SLOT_W-1:0]   w_cur_slot;
    logic [cps_pkg::BEAT_W-1:0]   w_len;
    logic [cps_pkg::COUNT_W-1:0]  w_slot_inc;
    logic [3:0]                   w_root_raw;

    // Handshake: the result register frees up when empty or drained this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Effective slot count and beat period
    assign w_nslots = (w_cfg.slot_count > cps_pkg::COUNT_W'(SLOTS))
                    ? cps_pkg::COUNT_W'(SLOTS) : w_cfg.slot_count;
    assign w_period = (w_cfg.beat_period == '0)
                    ? cps_pkg::PERIOD_W'(1) : w_cfg.beat_period;

    // Current slot folds back to 0 when beyond the active slots
    assign w_cur_slot = ({1'b0, r_slot} >= w_nslots) ? '0 : r_slot;
    assign w_len      = cps_pkg::beat_len(w_cfg.slot_beats[w_cur_slot*6 +: 6]);
    assign w_slot_inc = {1'b0, w_cur_slot} + cps_pkg::COUNT_W'(1);

    // Next state of the counters
    always_comb begin
        n_tick   = r_tick;
        n_beat   = r_beat;
        n_slot   = r_slot;
        n_pulse  = 1'b0;
        n_change = 1'b0;
        if (i_restart) begin
            n_tick = '0;
            n_beat = '0;
            n_slot = '0;
        end else if (w_nslots == '0) begin
            if (r_tick != cps_pkg::TICK_MAX) begin
                n_tick = r_tick + cps_pkg::PERIOD_W'(1);
            end
        end else begin
            n_slot = w_cur_slot;
            if (r_tick != cps_pkg::TICK_MAX) begin
                n_tick = r_tick + cps_pkg::PERIOD_W'(1);
            end
            if (n_tick >= w_period) begin
                n_tick  = '0;
                n_pulse = 1'b1;
                n_beat  = r_beat + cps_pkg::BEAT_W'(1);
                if (n_beat >= w_len) begin
                    n_beat   = '0;
                    n_change = 1'b1;
                    n_slot   = (w_slot_inc >= w_nslots) ? '0 : w_slot_inc[2:0];
                end
            end
        end
    end

    // Chord lookup for the updated position
    assign w_root_raw = w_cfg.slot_roots[n_slot*4 +: 4];

    always_comb begin
        n_active   = (w_nslots != '0);
        n_root     = (w_root_raw >= 4'd12) ? w_root_raw - 4'd12 : w_root_raw;
        n_minor    = w_cfg.slot_minor[n_slot];
        n_slot_idx = n_slot;
        n_beat_idx = n_beat[4:0];
        n_steps    = n_minor ? cps_pkg::MINOR_STEPS : cps_pkg::MAJOR_STEPS;
        if (!n_active) begin
            n_root     = '0;
            n_minor    = 1'b0;
            n_slot_idx = '0;
            n_beat_idx = '0;
            n_steps    = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_beat      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_tick <= n_tick;
                r_beat <= n_beat;
                r_slot <= n_slot;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_root     <= n_root;
            r_minor    <= n_minor;
            r_slot_idx <= n_slot_idx;
            r_beat_idx <= n_beat_idx;
            r_pulse    <= n_pulse && n_active;
            r_change   <= n_change && n_active;
            r_active   <= n_active;
            r_steps    <= n_steps;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_root_note    = r_root;
    assign o_is_minor     = r_minor;
    assign o_slot_index   = r_slot_idx;
    assign o_beat_index   = r_beat_idx;
    assign o_beat_pulse   = r_pulse;
    assign o_chord_change = r_change;
    assign o_active       = r_active;
    assign o_scale_steps  = r_steps;

endmodule

>>> verif/chord_progression_sequencer_core_tb.sv
// Self-checking testbench of the chord progression sequencer core: directed and random ticks.
module chord_progression_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The longest quiet stretch is the receiver hold-off plus random gaps and register writes
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RAND_PHASES    = 15;
    localparam int PHASE_ITEMS    = 58;
    localparam int HOLD_PHASE     = 12;
    localparam int RESTART_PCT    = 4;

    // One result of the sequencer
    typedef struct packed {
        logic [3:0]                  root;
        logic                        minor;
        logic [cps_pkg::SLOT_W-1:0]  slot;
        logic [4:0]                  beat;
        logic                        pulse;
        logic                        change;
        logic                        active;
        logic [cps_pkg::STEPS_W-1:0] steps;
    } t_chord;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        i_restart   = 1'b0;
    logic                        i_out_stall = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [cps_pkg::IDX_W-1:0]   i_cfg_index = '0;
    logic [cps_pkg::CFG_W-1:0]   i_cfg_data  = '0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [3:0]                  o_root_note;
    logic                        o_is_minor;
    logic [2:0]                  o_slot_index;
    logic [4:0]                  o_beat_index;
    logic                        o_beat_pulse;
    logic                        o_chord_change;
    logic                        o_active;
    logic [27:0]                 o_scale_steps;

    chord_progression_sequencer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_root_note    (o_root_note),
        .o_is_minor     (o_is_minor),
        .o_slot_index   (o_slot_index),
        .o_beat_index   (o_beat_index),
        .o_beat_pulse   (o_beat_pulse),
        .o_chord_change (o_chord_change),
        .o_active       (o_active),
        .o_scale_steps  (o_scale_steps),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the registers and counters
    logic [cps_pkg::PERIOD_W-1:0] cfg_period = cps_pkg::RST_BEAT_PERIOD;
    logic [cps_pkg::COUNT_W-1:0]  cfg_count  = cps_pkg::RST_SLOT_COUNT;
    logic [cps_pkg::ROOTS_W-1:0]  cfg_roots  = cps_pkg::RST_SLOT_ROOTS;
    logic [cps_pkg::MINOR_W-1:0]  cfg_minor  = cps_pkg::RST_SLOT_MINOR;
    logic [cps_pkg::BEATS_W-1:0]  cfg_beats  = cps_pkg::RST_SLOT_BEATS;
    logic [cps_pkg::PERIOD_W-1:0] tick_cnt   = '0;
    logic [cps_pkg::BEAT_W-1:0]   beat_cnt   = '0;
    logic [cps_pkg::SLOT_W-1:0]   cur_slot   = '0;

    logic   tick_items[$];      // restart flags waiting to be sent
    t_chord pending_chords[$];  // predicted results not yet seen

    int tx_idle_pct = 31;
    int rx_idle_pct = 62;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int errors      = 0;
    int n_items     = 0;
    int n_restarts  = 0;
    int n_beats     = 0;
    int n_changes   = 0;
    int n_cfg       = 0;
    int quiet_cycles = 0;

    // Advance the counters by one item and return the chord it reports
    function automatic t_chord advance_chord(input logic restart);
        int unsigned n;
        int unsigned period;
        int unsigned len;
        logic [3:0]  root;
        t_chord      r;
        n      = (cfg_count > cps_pkg::SLOTS) ? cps_pkg::SLOTS : 32'(cfg_count);
        period = (cfg_period == '0) ? 1 : 32'(cfg_period);
        r      = '0;
        if (restart) begin
            tick_cnt = '0;
            beat_cnt = '0;
            cur_slot = '0;
        end else if (n == 0) begin
            // idle sequencer still counts ticks, saturating
            if (tick_cnt != cps_pkg::TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        end else begin
            if (cur_slot >= n) cur_slot = '0;
            if (tick_cnt != cps_pkg::TICK_MAX) tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= period) begin
                tick_cnt = '0;
                r.pulse  = 1'b1;
                beat_cnt = beat_cnt + 1'b1;
                len = 32'(cfg_beats[cur_slot * 6 +: 6]);
                if (len == 0) len = 1;
                else if (len > 32) len = 32;
                if (beat_cnt >= len) begin
                    beat_cnt = '0;
                    cur_slot = cps_pkg::SLOT_W'((cur_slot + 1) % n);
                    r.change = 1'b1;
                end
            end
        end
        if (n == 0) return '0;
        root = cfg_roots[cur_slot * 4 +: 4];
        if (root >= 12) root = root - 4'd12;
        r.root   = root;
        r.minor  = cfg_minor[cur_slot];
        r.slot   = cur_slot;
        r.beat   = beat_cnt[4:0];
        r.active = 1'b1;
        r.steps  = r.minor ? cps_pkg::MINOR_STEPS : cps_pkg::MAJOR_STEPS;
        return r;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) note_error($sformatf("%s got %0h expected %0h", fname, got, want));
    endtask

    // Register write; the predictor copy follows at once since the block is idle
    task automatic write_reg(input cps_pkg::t_reg_idx idx,
                             input logic [cps_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            cps_pkg::REG_BEAT_PERIOD: cfg_period = val[cps_pkg::PERIOD_W-1:0];
            cps_pkg::REG_SLOT_COUNT:  cfg_count  = val[cps_pkg::COUNT_W-1:0];
            cps_pkg::REG_SLOT_ROOTS:  cfg_roots  = val[cps_pkg::ROOTS_W-1:0];
            cps_pkg::REG_SLOT_MINOR:  cfg_minor  = val[cps_pkg::MINOR_W-1:0];
            cps_pkg::REG_SLOT_BEATS:  cfg_beats  = val[cps_pkg::BEATS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    // Wait until every item is sent and every result checked
    task automatic drain();
        @(negedge i_clk);
        while (tick_items.size() != 0 || i_in_valid || pending_chords.size() != 0)
            @(negedge i_clk);
    endtask

    // Queue a directed run of items, bit 0 of the pattern first
    task automatic offer(input logic [31:0] pattern, input int count);
        @(negedge i_clk);
        for (int b = 0; b < count; b++) tick_items.push_back(pattern[b]);
    endtask

    // Sender: the payload holds until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (tick_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_restart  <= tick_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Result check, prediction of accepted items and watchdog
    always @(posedge i_clk) begin : monitor
        t_chord want;
        t_chord next;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_chords.size() == 0) begin
                    note_error("result with no item waiting");
                end else begin
                    want = pending_chords.pop_front();
                    check_field("root_note", o_root_note, want.root);
                    check_field("is_minor", o_is_minor, want.minor);
                    check_field("slot_index", o_slot_index, want.slot);
                    check_field("beat_index", o_beat_index, want.beat);
                    check_field("beat_pulse", o_beat_pulse, want.pulse);
                    check_field("chord_change", o_chord_change, want.change);
                    check_field("active", o_active, want.active);
                    check_field("scale_steps", o_scale_steps, want.steps);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                next  = advance_chord(i_restart);
                pending_chords.push_back(next);
                n_items++;
                n_restarts += i_restart;
                n_beats    += next.pulse;
                n_changes  += next.change;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [cps_pkg::PERIOD_W-1:0] period_v;
        logic [cps_pkg::COUNT_W-1:0]  count_v;
        logic [cps_pkg::ROOTS_W-1:0]  roots_v;
        logic [cps_pkg::MINOR_W-1:0]  minor_v;
        logic [cps_pkg::BEATS_W-1:0]  beats_v;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: no slot active, results all zero
        offer(32'b0100, 4);
        drain();

        // Period zero, roots above 11, zero and nonzero beat lengths
        write_reg(cps_pkg::REG_BEAT_PERIOD, '0);
        write_reg(cps_pkg::REG_SLOT_COUNT, 48'd3);
        write_reg(cps_pkg::REG_SLOT_ROOTS, 48'h0000_0FDC);
        write_reg(cps_pkg::REG_SLOT_MINOR, 48'b0000_0010);
        write_reg(cps_pkg::REG_SLOT_BEATS, (48'd2 << 12) | (48'd3 << 6));
        close_writes();
        offer(32'b0100001, 7);
        drain();

        // Ticks pile up while idle; a beat follows at once on activation
        write_reg(cps_pkg::REG_SLOT_COUNT, 48'd0);
        write_reg(cps_pkg::REG_BEAT_PERIOD, 48'd3);
        close_writes();
        offer(32'b0, 5);
        drain();
        write_reg(cps_pkg::REG_SLOT_COUNT, 48'd15);
        close_writes();
        offer(32'b0, 1);
        drain();

        // Step past slot 1, then shrink the slot count under the current slot
        write_reg(cps_pkg::REG_BEAT_PERIOD, 48'd1);
        write_reg(cps_pkg::REG_SLOT_BEATS, '0);
        close_writes();
        offer(32'b0, 4);
        drain();
        write_reg(cps_pkg::REG_SLOT_COUNT, 48'd2);
        close_writes();
        offer(32'b0, 1);
        drain();

        // Longest period: no beat
        write_reg(cps_pkg::REG_BEAT_PERIOD, cps_pkg::CFG_W'(cps_pkg::TICK_MAX));
        close_writes();
        offer(32'b0, 2);

        // Random phases; state carries over so a slot may fall outside the new count
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 5) begin
                tx_idle_pct = 31;
                rx_idle_pct = 62;
            end else if (p < 10) begin
                tx_idle_pct = 62;
                rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0:       period_v = '0;
                1:       period_v = cps_pkg::PERIOD_W'($urandom_range(4, 12));
                default: period_v = cps_pkg::PERIOD_W'($urandom_range(1, 3));
            endcase
            count_v = ($urandom_range(0, 9) == 0)
                    ? cps_pkg::COUNT_W'($urandom_range(0, 15))
                    : cps_pkg::COUNT_W'($urandom_range(1, 8));
            roots_v = $urandom;
            minor_v = cps_pkg::MINOR_W'($urandom);
            for (int k = 0; k < cps_pkg::SLOTS; k++) begin
                beats_v[k * 6 +: 6] = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                                  : 6'($urandom_range(0, 4));
            end
            // extremes of the registers
            if (p == 0) begin
                period_v = cps_pkg::PERIOD_W'(1);
                count_v  = '1;
                roots_v  = '1;
                minor_v  = '1;
                beats_v  = '1;
            end else if (p == 1) begin
                count_v = cps_pkg::COUNT_W'(cps_pkg::SLOTS);
                roots_v = '0;
                minor_v = '0;
                beats_v = '0;
            end else if (p == 2) begin
                period_v = '1;
            end
            drain();
            write_reg(cps_pkg::REG_BEAT_PERIOD, cps_pkg::CFG_W'(period_v));
            write_reg(cps_pkg::REG_SLOT_COUNT, cps_pkg::CFG_W'(count_v));
            write_reg(cps_pkg::REG_SLOT_ROOTS, cps_pkg::CFG_W'(roots_v));
            write_reg(cps_pkg::REG_SLOT_MINOR, cps_pkg::CFG_W'(minor_v));
            write_reg(cps_pkg::REG_SLOT_BEATS, beats_v);
            close_writes();
            @(negedge i_clk);
            for (int j = 0; j < PHASE_ITEMS; j++)
                tick_items.push_back($urandom_range(0, 99) < RESTART_PCT);
            // receiver holds off while the sender keeps offering, filling the block
            if (p == HOLD_PHASE) hold_req = 1'b1;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (pending_chords.size() != 0) note_error("results missing at end of run");
        $display("Checked %0d items (%0d restarts) across %0d register settings,",
                 n_items, n_restarts, n_cfg);
        $display("seeing %0d beat pulses and %0d chord changes.", n_beats, n_changes);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> chord_progression_sequencer_core.f
hw/rtl/cps_pkg.sv
hw/rtl/cps_cfg.sv
hw/rtl/chord_progression_sequencer_core.sv
verif/chord_progression_sequencer_core_tb.sv
